[rtl/ilie_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_pkg: shared types and codes for the indexed list
// Request and response payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package ilie_pkg;

    localparam int POS_W     = 7;
    localparam int DATA_IN_W = 32;
    localparam int COUNT_W   = 7;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic [POS_W-1:0]            position;
        logic signed [DATA_IN_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_IN_W-1:0] read_data;
        logic [1:0]                  status;
        logic [COUNT_W-1:0]          count;
    } rsp_t;

endpackage
`default_nettype wire

[rtl/indexed_list_insert_erase.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_erase: ordered list with insert, append, erase, read
// Entries sit in a single-port-write, registered-read memory; insert and
// erase move the tail one entry at a time under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  req     | in        | req_valid/req_stall | opcode, position, data_in
//  rsp     | out       | rsp_valid/rsp_stall | read_data, status, count
//
//  append and rejected transactions go straight to the finish state; read waits
//  for the registered memory read; insert and erase move each entry of the
//  tail through the memory's one read and one write port (each moved entry is
//  a read cycle then a write cycle)
//  reset clears the count and the sequencer; memory contents are not cleared
//  req_stall is high while a transaction is in progress; a finished response
//  waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
module indexed_list_insert_erase #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ilie_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ilie_pkg::rsp_t     rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ilie_pkg::POS_W) ? CW : ilie_pkg::POS_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SHIFT_RD  = 3'd1;
    localparam logic [2:0] S_SHIFT_WR  = 3'd2;
    localparam logic [2:0] S_READ_WAIT = 3'd3;
    localparam logic [2:0] S_FINISH    = 3'd4;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [2:0]            state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [1:0]            st_reg, st_next;
    logic signed [ilie_pkg::DATA_IN_W-1:0] rd_reg, rd_next;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  rsp_valid_reg, rsp_valid_next;
    ilie_pkg::rsp_t        rsp_reg, rsp_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    logic                  accept;
    logic [CMPW-1:0]       pos_ext, cnt_ext;
    logic signed [63:0]    in_ext, rd_ext;
    logic [DATA_WIDTH-1:0] in_val;
    logic                  is_insert;
    logic [CW-1:0]         step;
    logic                  more_work;
    logic                  rsp_free;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign pos_ext = CMPW'(req.position);
    assign cnt_ext = CMPW'(cnt_reg);
    assign in_ext  = 64'(req.data_in);
    assign in_val  = in_ext[DATA_WIDTH-1:0];
    assign rd_ext  = 64'(signed'(rdata_reg));

    // shared index unit: one adder and the loop-end compare
    assign is_insert = (op_reg == ilie_pkg::OP_INSERT);
    assign step      = is_insert ? CW'(idx_reg) - CW'(1) : CW'(idx_reg) + CW'(1);
    assign more_work = is_insert ? (idx_reg > pos_reg) : (step < cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        rd_next        = rd_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rdata_reg;
        mem_re         = 1'b0;
        mem_raddr      = step[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.opcode;
                    pos_next = AW'(req.position);
                    val_next = in_val;
                    st_next  = ilie_pkg::ST_DONE;
                    rd_next  = '0;
                    state_next = S_FINISH;
                    unique case (req.opcode)
                        ilie_pkg::OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                                st_next = ilie_pkg::ST_BAD_INDEX;
                            else if (cnt_reg == CW'(DEPTH))
                                st_next = ilie_pkg::ST_FULL;
                            else
                            begin
                                idx_next   = AW'(cnt_reg);
                                state_next = S_SHIFT_RD;
                            end
                        end
                        ilie_pkg::OP_APPEND:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                                st_next = ilie_pkg::ST_FULL;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(cnt_reg);
                                mem_wdata = in_val;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        ilie_pkg::OP_ERASE:
                        begin
                            if (pos_ext >= cnt_ext)
                                st_next = ilie_pkg::ST_BAD_INDEX;
                            else
                            begin
                                idx_next   = AW'(req.position);
                                state_next = S_SHIFT_RD;
                            end
                        end
                        default:
                        begin
                            if (pos_ext >= cnt_ext)
                                st_next = ilie_pkg::ST_BAD_INDEX;
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(req.position);
                                state_next = S_READ_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_RD:
            begin
                if (more_work)
                begin
                    mem_re     = 1'b1;
                    state_next = S_SHIFT_WR;
                end
                else if (is_insert)
                begin
                    // tail moved up, drop the new value into the gap
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = step[AW-1:0];
                state_next = S_SHIFT_RD;
            end
            S_READ_WAIT:
            begin
                rd_next    = rd_ext[ilie_pkg::DATA_IN_W-1:0];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.read_data = rd_reg;
                    rsp_next.status    = st_reg;
                    rsp_next.count     = ilie_pkg::COUNT_W'(cnt_reg);
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        rd_reg  <= rd_next;
        rsp_reg <= rsp_next;
    end

    // list storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CW'(1))
        || (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == ilie_pkg::ST_FULL)
        |-> (rsp_reg.count == ilie_pkg::COUNT_W'(DEPTH)))
        else $error("full status with list not full");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != ilie_pkg::ST_DONE)
        |-> (rsp_reg.read_data == '0))
        else $error("failed transaction returned data");

endmodule
`default_nettype wire
